// File: rtl/kqtg_pkg.sv
package kqtg_pkg;

	localparam int SINE_INDEX_BITS = 10;
	localparam int LENGTH_BITS     = 20;

	localparam int IN_LEN_BITS    = 20;
	localparam int PHASE_BITS     = 32;
	localparam int FADE_BITS      = 16;
	localparam int CFG_DATA_BITS  = 32;
	localparam int CFG_INDEX_BITS = 2;
	localparam int SAMPLE_BITS    = 16;

	localparam int CORDIC_STEPS = 18;
	localparam int STEP_BITS    = $clog2(CORDIC_STEPS);
	localparam int XY_BITS      = 34;
	localparam int Z_BITS       = 34;
	localparam int TRIG_BITS    = 32;
	localparam int ENV_BITS     = FADE_BITS + 1;
	localparam int PROD_BITS    = 48;
	localparam int SCALED_BITS  = PROD_BITS + 16;
	localparam int PCM_SHIFT    = 46;
	localparam int SUM_BITS     = (LENGTH_BITS > FADE_BITS ? LENGTH_BITS : FADE_BITS) + 1;

	localparam logic [PHASE_BITS-1:0] QUANT_MASK =
		~((PHASE_BITS'(1) << (PHASE_BITS - SINE_INDEX_BITS)) - PHASE_BITS'(1));

	localparam logic signed [XY_BITS-1:0] CORDIC_X0 = XY_BITS'(652032874);
	localparam logic signed [XY_BITS-1:0] ONE_Q30   = XY_BITS'(1) << 30;
	localparam logic [ENV_BITS-1:0]       ENV_ONE   = ENV_BITS'(1) << FADE_BITS;

	// arctangent of 2^-i in 2^-32 turns
	localparam logic signed [Z_BITS-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
		Z_BITS'(536870912), Z_BITS'(316933406), Z_BITS'(167458907),
		Z_BITS'(85004756),  Z_BITS'(42667331),  Z_BITS'(21354465),
		Z_BITS'(10680862),  Z_BITS'(5340245),   Z_BITS'(2670163),
		Z_BITS'(1335087),   Z_BITS'(667544),    Z_BITS'(333772),
		Z_BITS'(166886),    Z_BITS'(83443),     Z_BITS'(41722),
		Z_BITS'(20861),     Z_BITS'(10430),     Z_BITS'(5215)
	};

	typedef enum logic {
		KIND_BEGIN = 1'b0,
		KIND_TICK  = 1'b1
	} kind_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_PHASE_STEP   = 2'd0,
		REG_FADE_SAMPLES = 2'd1,
		REG_FADE_GAIN    = 2'd2,
		REG_SWAP_BYTES   = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROT,
		ST_FIX,
		ST_ENV,
		ST_MUL,
		ST_PCM
	} ctrl_state_t;

	typedef struct packed {
		logic                 load_elem;
		logic                 start;
		logic                 rot;
		logic                 fix;
		logic                 env;
		logic                 mul;
		logic                 load_out;
		logic [STEP_BITS-1:0] step;
	} dp_cmd_t;

	typedef struct packed {
		logic active;
		logic out_free;
	} dp_status_t;

endpackage

// File: rtl/keyed_quadrature_tone_generator.sv
// Keyed quadrature tone generator. A begin transaction (kind 0) loads one keying element
// (length, tone or silence); a tick transaction (kind 1) with no element active is
// accepted and gives nothing. A tick inside an element gives one I/Q sample:
// I = sin(phase), Q = -cos(phase), scaled by a linear fade-in/fade-out envelope and 32767,
// with last set on the element's final sample. That sample is made by one shared CORDIC
// rotator doing 18 rotations, one per cycle, followed by clamping/ramps, envelope, multiply
// and scaling steps. The block takes no new transaction until that sample has left its
// last step for the output register. A finished sample waits in the output register while
// the block takes new transactions; a second sample waits in its last step until that
// register drains. Configuration registers may only be written while the block is idle.
module keyed_quadrature_tone_generator (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_we,
	input  logic [kqtg_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
	input  logic [kqtg_pkg::CFG_DATA_BITS-1:0]      cfg_data,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic                                    kind,
	input  logic [kqtg_pkg::IN_LEN_BITS-1:0]        length_samples,
	input  logic                                    tone_on,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [kqtg_pkg::SAMPLE_BITS-1:0] sample_i,
	output logic signed [kqtg_pkg::SAMPLE_BITS-1:0] sample_q,
	output logic                                    last
);

	kqtg_pkg::dp_cmd_t    cmd;
	kqtg_pkg::dp_status_t status;

	kqtg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.kind     (kind),
		.status   (status),
		.cmd      (cmd)
	);

	kqtg_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.length_samples (length_samples),
		.tone_on        (tone_on),
		.cmd            (cmd),
		.status         (status),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.sample_i       (sample_i),
		.sample_q       (sample_q),
		.last           (last)
	);

endmodule

// File: rtl/kqtg_ctrl.sv
module kqtg_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                kind,
	input  kqtg_pkg::dp_status_t status,
	output kqtg_pkg::dp_cmd_t    cmd
);

	kqtg_pkg::ctrl_state_t state_q, state_nx;
	logic [kqtg_pkg::STEP_BITS-1:0] step_q, step_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kqtg_pkg::ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_nx;
			step_q  <= step_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		step_nx  = step_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.step = step_q;
		unique case (state_q)
			kqtg_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				step_nx  = '0;
				if (in_valid) begin
					if (kqtg_pkg::kind_t'(kind) == kqtg_pkg::KIND_BEGIN) begin
						cmd.load_elem = 1'b1;
					end else if (status.active) begin
						cmd.start = 1'b1;
						state_nx  = kqtg_pkg::ST_ROT;
					end
				end
			end
			kqtg_pkg::ST_ROT: begin
				cmd.rot = 1'b1;
				if (step_q == kqtg_pkg::STEP_BITS'(kqtg_pkg::CORDIC_STEPS - 1)) begin
					state_nx = kqtg_pkg::ST_FIX;
				end else begin
					step_nx = step_q + 1'b1;
				end
			end
			kqtg_pkg::ST_FIX: begin
				cmd.fix  = 1'b1;
				state_nx = kqtg_pkg::ST_ENV;
			end
			kqtg_pkg::ST_ENV: begin
				cmd.env  = 1'b1;
				state_nx = kqtg_pkg::ST_MUL;
			end
			kqtg_pkg::ST_MUL: begin
				cmd.mul  = 1'b1;
				state_nx = kqtg_pkg::ST_PCM;
			end
			kqtg_pkg::ST_PCM: begin
				// hold until the output register can take the result
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_nx     = kqtg_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nx = kqtg_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/kqtg_datapath.sv
module kqtg_datapath (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cfg_we,
	input  logic [kqtg_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
	input  logic [kqtg_pkg::CFG_DATA_BITS-1:0]       cfg_data,
	input  logic [kqtg_pkg::IN_LEN_BITS-1:0]         length_samples,
	input  logic                                     tone_on,
	input  kqtg_pkg::dp_cmd_t                        cmd,
	output kqtg_pkg::dp_status_t                     status,
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output logic signed [kqtg_pkg::SAMPLE_BITS-1:0]  sample_i,
	output logic signed [kqtg_pkg::SAMPLE_BITS-1:0]  sample_q,
	output logic                                     last
);

	localparam int LB = kqtg_pkg::LENGTH_BITS;

	// configuration
	logic [kqtg_pkg::PHASE_BITS-1:0] phase_step_q;
	logic [kqtg_pkg::FADE_BITS-1:0]  fade_samples_q;
	logic [kqtg_pkg::FADE_BITS-1:0]  fade_gain_q;
	logic                            swap_q;

	// element state
	logic [kqtg_pkg::PHASE_BITS-1:0] phase_acc_q;
	logic [LB-1:0]                   pos_q;
	logic [LB-1:0]                   len_q;
	logic                            tone_q;
	logic                            active_q;

	// per-sample working registers
	logic [LB-1:0]                          wpos_q;
	logic                                   wlast_q;
	logic                                   flip_q;
	logic signed [kqtg_pkg::XY_BITS-1:0]    x_q, y_q;
	logic signed [kqtg_pkg::Z_BITS-1:0]     z_q;
	logic signed [kqtg_pkg::TRIG_BITS-1:0]  trig_i_q, trig_q_q;
	logic [kqtg_pkg::ENV_BITS-1:0]          ramp_a_q, ramp_b_q, env_q;
	logic signed [kqtg_pkg::PROD_BITS-1:0]  prod_i_q, prod_q_q;
	logic signed [kqtg_pkg::SAMPLE_BITS-1:0] out_i_q, out_q_q;
	logic                                   out_last_q;
	logic                                   out_valid_q;

	// start of a sample
	logic [kqtg_pkg::PHASE_BITS-1:0] angle;
	logic                            fold;
	logic [kqtg_pkg::PHASE_BITS-1:0] folded;
	logic [LB:0]                     pos_inc;
	logic                            is_last;

	// rotator
	logic signed [kqtg_pkg::XY_BITS-1:0] sx, sy, x_nx, y_nx;
	logic signed [kqtg_pkg::Z_BITS-1:0]  z_nx;

	// fix and ramps
	logic signed [kqtg_pkg::XY_BITS-1:0] xf, yf;
	logic [kqtg_pkg::SUM_BITS-1:0]       pos_ext, fade_ext, len_ext;
	logic                                fade_off, in_on, out_on;
	logic [kqtg_pkg::FADE_BITS-1:0]      n_in, n_out;
	logic [2*kqtg_pkg::FADE_BITS-1:0]    ra_full, rb_full;

	// envelope and products
	logic [2*kqtg_pkg::ENV_BITS-1:0]     ab;
	logic signed [kqtg_pkg::TRIG_BITS+kqtg_pkg::ENV_BITS:0] pi_full, pq_full;

	function automatic logic signed [kqtg_pkg::TRIG_BITS-1:0] clamp_q30(
		input logic signed [kqtg_pkg::XY_BITS-1:0] v
	);
		logic signed [kqtg_pkg::XY_BITS-1:0] r;
		r = v;
		if (v > kqtg_pkg::ONE_Q30) begin
			r = kqtg_pkg::ONE_Q30;
		end else if (v < -kqtg_pkg::ONE_Q30) begin
			r = -kqtg_pkg::ONE_Q30;
		end
		return kqtg_pkg::TRIG_BITS'(r);
	endfunction

	function automatic logic [kqtg_pkg::ENV_BITS-1:0] sat_ramp(
		input logic [2*kqtg_pkg::FADE_BITS-1:0] f
	);
		logic [kqtg_pkg::ENV_BITS-1:0] r;
		r = kqtg_pkg::ENV_ONE;
		if (f <= (2*kqtg_pkg::FADE_BITS)'(kqtg_pkg::ENV_ONE)) begin
			r = kqtg_pkg::ENV_BITS'(f);
		end
		return r;
	endfunction

	// product * 32767 / 2^46, truncated toward zero, then optional byte swap
	function automatic logic [kqtg_pkg::SAMPLE_BITS-1:0] to_pcm(
		input logic signed [kqtg_pkg::PROD_BITS-1:0] p,
		input logic                                 swap
	);
		logic signed [kqtg_pkg::SCALED_BITS-1:0] pe, scaled, biased;
		logic [kqtg_pkg::SAMPLE_BITS-1:0]        v;
		pe     = kqtg_pkg::SCALED_BITS'(p);
		scaled = (pe <<< 15) - pe;
		biased = scaled;
		if (scaled < 0) begin
			biased = scaled + ((kqtg_pkg::SCALED_BITS'(1) << kqtg_pkg::PCM_SHIFT) - 1);
		end
		v = kqtg_pkg::SAMPLE_BITS'(biased >>> kqtg_pkg::PCM_SHIFT);
		if (swap) begin
			v = {v[7:0], v[15:8]};
		end
		return v;
	endfunction

	always_comb begin
		angle   = phase_acc_q & kqtg_pkg::QUANT_MASK;
		// fold the left half-plane onto the right, negate at the end
		fold    = angle[kqtg_pkg::PHASE_BITS-1] ^ angle[kqtg_pkg::PHASE_BITS-2];
		folded  = angle ^ {fold, {(kqtg_pkg::PHASE_BITS-1){1'b0}}};
		pos_inc = {1'b0, pos_q} + 1'b1;
		is_last = pos_inc >= {1'b0, len_q};
	end

	always_comb begin
		sy = y_q >>> cmd.step;
		sx = x_q >>> cmd.step;
		if (!z_q[kqtg_pkg::Z_BITS-1]) begin
			x_nx = x_q - sy;
			y_nx = y_q + sx;
			z_nx = z_q - kqtg_pkg::ATAN_TURNS[cmd.step];
		end else begin
			x_nx = x_q + sy;
			y_nx = y_q - sx;
			z_nx = z_q + kqtg_pkg::ATAN_TURNS[cmd.step];
		end
	end

	always_comb begin
		xf       = flip_q ? -x_q : x_q;
		yf       = flip_q ? -y_q : y_q;
		pos_ext  = kqtg_pkg::SUM_BITS'(wpos_q);
		fade_ext = kqtg_pkg::SUM_BITS'(fade_samples_q);
		len_ext  = kqtg_pkg::SUM_BITS'(len_q);
		fade_off = fade_samples_q == '0;
		in_on    = pos_ext <= fade_ext;
		out_on   = pos_ext + fade_ext >= len_ext;
		n_in     = kqtg_pkg::FADE_BITS'(wpos_q);
		n_out    = kqtg_pkg::FADE_BITS'(len_q - wpos_q);
		ra_full  = n_in * fade_gain_q;
		rb_full  = n_out * fade_gain_q;
		ab       = ramp_a_q * ramp_b_q;
		pi_full  = trig_i_q * $signed({1'b0, env_q});
		pq_full  = trig_q_q * $signed({1'b0, env_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q   <= '0;
			fade_samples_q <= '0;
			fade_gain_q    <= '0;
			swap_q         <= 1'b0;
			phase_acc_q    <= '0;
			pos_q          <= '0;
			len_q          <= '0;
			tone_q         <= 1'b0;
			active_q       <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (kqtg_pkg::cfg_reg_t'(cfg_index))
					kqtg_pkg::REG_PHASE_STEP:   phase_step_q   <= cfg_data;
					kqtg_pkg::REG_FADE_SAMPLES: fade_samples_q <= cfg_data[kqtg_pkg::FADE_BITS-1:0];
					kqtg_pkg::REG_FADE_GAIN:    fade_gain_q    <= cfg_data[kqtg_pkg::FADE_BITS-1:0];
					kqtg_pkg::REG_SWAP_BYTES:   swap_q         <= cfg_data[0];
				endcase
			end
			if (cmd.load_elem) begin
				len_q    <= LB'(length_samples);
				tone_q   <= tone_on;
				pos_q    <= '0;
				active_q <= LB'(length_samples) != '0;
			end
			if (cmd.start) begin
				phase_acc_q <= phase_acc_q + phase_step_q;
				pos_q       <= LB'(pos_inc);
				if (is_last) begin
					active_q <= 1'b0;
				end
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			wpos_q  <= pos_q;
			wlast_q <= is_last;
			flip_q  <= fold;
			x_q     <= kqtg_pkg::CORDIC_X0;
			y_q     <= '0;
			z_q     <= {{(kqtg_pkg::Z_BITS-kqtg_pkg::PHASE_BITS){folded[kqtg_pkg::PHASE_BITS-1]}},
				folded};
		end
		if (cmd.rot) begin
			x_q <= x_nx;
			y_q <= y_nx;
			z_q <= z_nx;
		end
		if (cmd.fix) begin
			trig_i_q <= clamp_q30(yf);
			trig_q_q <= -clamp_q30(xf);
			ramp_a_q <= (fade_off || !in_on) ? kqtg_pkg::ENV_ONE : sat_ramp(ra_full);
			ramp_b_q <= (fade_off || !out_on) ? kqtg_pkg::ENV_ONE : sat_ramp(rb_full);
		end
		if (cmd.env) begin
			env_q <= tone_q ? kqtg_pkg::ENV_BITS'(ab >> kqtg_pkg::FADE_BITS) : '0;
		end
		if (cmd.mul) begin
			prod_i_q <= kqtg_pkg::PROD_BITS'(pi_full);
			prod_q_q <= kqtg_pkg::PROD_BITS'(pq_full);
		end
		if (cmd.load_out) begin
			out_i_q    <= to_pcm(prod_i_q, swap_q);
			out_q_q    <= to_pcm(prod_q_q, swap_q);
			out_last_q <= wlast_q;
		end
	end

	assign status.active   = active_q;
	assign status.out_free = !out_valid_q || out_ready;
	assign out_valid       = out_valid_q;
	assign sample_i        = out_i_q;
	assign sample_q        = out_q_q;
	assign last            = out_last_q;

endmodule

// File: rtl/kqtg_checker.sv
module kqtg_checker (
	input logic                                    clk,
	input logic                                    arst_n,
	input logic                                    in_valid,
	input logic                                    in_ready,
	input logic                                    kind,
	input logic                                    out_valid,
	input logic                                    out_ready,
	input logic signed [kqtg_pkg::SAMPLE_BITS-1:0] sample_i,
	input logic signed [kqtg_pkg::SAMPLE_BITS-1:0] sample_q,
	input logic                                    last
);

	// a held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample_i) && $stable(sample_q)
			&& $stable(last))
		else $error("output payload changed while stalled");

	// a begin transaction never produces a sample
	a_begin_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && kind == kqtg_pkg::KIND_BEGIN |=> !$rose(out_valid))
		else $error("sample appeared right after a begin transaction");

	// a new sample appears only as the engine returns to idle
	a_rise_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready && !$past(in_ready))
		else $error("sample appeared while input side was not busy");

	// once busy with a sample, the rotator keeps the input closed
	a_busy_span: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |=> !in_ready)
		else $error("input reopened too early");

endmodule

bind keyed_quadrature_tone_generator kqtg_checker u_kqtg_checker (.*);
